>>> hdl/edfs_pkg.sv
// Package for the EDF / fixed-priority task scheduler.
// Shared constants, command and status codes, and controller/datapath structs.
`timescale 1ns / 1ps
package edfs_pkg;
  localparam int MaxTasks = 8;
  localparam int SlotW = $clog2(MaxTasks);
  localparam logic [31:0] CeilingReset = 32'd100;
  localparam logic [15:0] PendingMax = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_TICK     = 3'd2,
    CMD_COMPLETE = 3'd3,
    CMD_SCHEDULE = 3'd4,
    CMD_QUERY    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_DL  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;    // capture input transaction, clear scan state
    logic             scan;    // process slot scan_idx
    logic [SlotW-1:0] scan_idx;
    logic             finish;  // form result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             multi;   // captured command walks slots
  } dp_stat_t;
endpackage

>>> hdl/edf_fixed_priority_task_scheduler.sv
// Top level of the EDF / fixed-priority task scheduler: ports, ceiling
// register, output register. Depends on edfs_pkg, edfs_ctrl, edfs_dp.
`timescale 1ns / 1ps
// One command is handled at a time. Create, delete, tick and schedule walk the
// task slots 1..7 one per cycle through a single slot-processing datapath: the
// controller steps from load through the slot walk to a done step, where the
// result is formed. Complete, query and unknown commands skip the walk and go
// straight from the load step to the done step.
// The result sits in an output register; the next command is accepted as soon
// as the controller is idle, even while that result waits to be taken, and
// that next command then waits in its last step until the register is free.
// fixed_priority_ceiling resets to 100 and is written by cfg_we.
module edf_fixed_priority_task_scheduler
  import edfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_task_ref,
  input  logic [31:0] in_period_ticks,
  input  logic [31:0] in_phase_ticks,
  input  logic [31:0] in_prio_or_deadline,
  input  logic        in_is_edf,
  input  logic [31:0] in_current_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot_index,
  output logic [7:0]  out_chosen_id,
  output logic        out_context_switch,
  output logic [15:0] out_pending_jobs,
  output logic [31:0] out_deadline_out,
  output logic [31:0] out_period_out,
  output logic [31:0] out_priority_out,
  output logic        out_alive,
  output logic        out_schedule_requested
);
  logic [31:0] ceiling_r;
  logic        out_valid_r;
  logic        idle, in_fire;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign in_ready  = idle;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Hold ceiling and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r   <= CeilingReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) ceiling_r <= cfg_wdata;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  edfs_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .out_busy (out_valid_r && !out_ready),
    .stat, .cmd, .idle
  );

  edfs_dp u_dp (
    .clk, .rst_n, .cmd, .stat,
    .ceiling (ceiling_r),
    .in_command, .in_task_ref, .in_period_ticks, .in_phase_ticks,
    .in_prio_or_deadline, .in_is_edf, .in_current_time,
    .res_status (out_status),
    .res_slot_index (out_slot_index),
    .res_chosen_id (out_chosen_id),
    .res_context_switch (out_context_switch),
    .res_pending_jobs (out_pending_jobs),
    .res_deadline_out (out_deadline_out),
    .res_period_out (out_period_out),
    .res_priority_out (out_priority_out),
    .res_alive (out_alive),
    .res_schedule_requested (out_schedule_requested)
  );

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
    && $stable(out_slot_index)) else $error("result dropped");
  // No new transaction while one is in work
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready) else $error("overlapping transactions");
  // Each finished result makes the output valid
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("result lost");
endmodule

>>> hdl/edfs_ctrl.sv
// Controller FSM for the EDF scheduler: sequences load, slot walk, result.
// Depends on edfs_pkg.
`timescale 1ns / 1ps
module edfs_ctrl
  import edfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     idle
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SlotW-1:0] idx_r, idx_nxt;

  // Advance through the slots one per cycle
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.scan_idx = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        idx_nxt   = SlotW'(1);
        state_nxt = stat.multi ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == SlotW'(MaxTasks - 1)) state_nxt = S_DONE;
        else idx_nxt = idx_r + SlotW'(1);
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

  // Scan covers only real task slots
  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> idx_r != '0) else $error("scan of idle slot");
  // A finish only follows a done state with free output
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_busy) else $error("finish while output busy");
  // Load only from idle
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_LOAD) else $error("load sequencing");
endmodule

>>> hdl/edfs_dp.sv
// Datapath for the EDF scheduler: task table, per-slot walk, result forming.
// Depends on edfs_pkg.
`timescale 1ns / 1ps
module edfs_dp
  import edfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [31:0] ceiling,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_task_ref,
  input  logic [31:0] in_period_ticks,
  input  logic [31:0] in_phase_ticks,
  input  logic [31:0] in_prio_or_deadline,
  input  logic        in_is_edf,
  input  logic [31:0] in_current_time,
  output logic [1:0]  res_status,
  output logic [2:0]  res_slot_index,
  output logic [7:0]  res_chosen_id,
  output logic        res_context_switch,
  output logic [15:0] res_pending_jobs,
  output logic [31:0] res_deadline_out,
  output logic [31:0] res_period_out,
  output logic [31:0] res_priority_out,
  output logic        res_alive,
  output logic        res_schedule_requested
);
  // Slot table
  logic [MaxTasks-1:0] valid_r, active_r;
  logic [7:0]          id_r   [MaxTasks];
  logic [31:0]         per_r  [MaxTasks];
  logic [31:0]         rel_r  [MaxTasks];
  logic [31:0]         pri_r  [MaxTasks];
  logic [31:0]         dl_r   [MaxTasks];
  logic [15:0]         pend_r [MaxTasks];
  logic [SlotW-1:0]    cur_r;
  logic                resched_r;

  // Captured transaction
  cmd_t        c_r;
  logic [7:0]  ref_r;
  logic [31:0] per_in_r, rel_in_r, pd_r, now_r;
  logic        edf_in_r;

  // Walk accumulators
  logic [SlotW-1:0] free_r, best_r;
  logic             free_ok_r, found_r, best_edf_r;
  logic [31:0]      best_pri_r;

  assign stat.multi = (c_r == CMD_CREATE) || (c_r == CMD_DELETE) ||
                      (c_r == CMD_TICK) || (c_r == CMD_SCHEDULE);

  logic [SlotW-1:0] i;
  assign i = cmd.scan_idx;

  // Complete and query target
  logic             ref_ok;
  logic [SlotW-1:0] rs;
  assign rs = ref_r[SlotW-1:0];
  assign ref_ok = (ref_r < 8'(MaxTasks)) && (rs != '0) && valid_r[rs] && active_r[rs];

  logic [31:0] rel_sum;
  assign rel_sum = now_r + rel_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      active_r  <= '0;
      cur_r     <= '0;
      resched_r <= 1'b0;
      for (int k = 0; k < MaxTasks; k++) id_r[k] <= '0;
    end else begin
      // Capture and reset walk state
      if (cmd.load) begin
        c_r        <= cmd_t'(in_command);
        ref_r      <= in_task_ref;
        per_in_r   <= in_period_ticks;
        rel_in_r   <= in_phase_ticks;
        pd_r       <= in_prio_or_deadline;
        edf_in_r   <= in_is_edf;
        now_r      <= in_current_time;
        free_ok_r  <= 1'b0;
        free_r     <= '0;
        found_r    <= 1'b0;
        best_r     <= '0;
        best_edf_r <= 1'b0;
        best_pri_r <= ceiling;
      end
      // Process one slot
      if (cmd.scan) begin
        case (c_r)
          CMD_CREATE: begin
            if (!valid_r[i] && !free_ok_r) begin
              free_ok_r <= 1'b1;
              free_r    <= i;
            end
          end
          CMD_DELETE: begin
            if (valid_r[i] && id_r[i] == ref_r) begin
              active_r[i] <= 1'b0;
              found_r     <= 1'b1;
            end
          end
          CMD_TICK: begin
            if (valid_r[i] && active_r[i] && now_r >= rel_r[i]) begin
              rel_r[i] <= rel_r[i] + per_r[i];
              if (pend_r[i] != PendingMax) pend_r[i] <= pend_r[i] + 16'd1;
              resched_r <= 1'b1;
            end
          end
          CMD_SCHEDULE: begin
            if (valid_r[i] && pend_r[i] != '0) begin
              if (best_edf_r) begin
                if (dl_r[i] != '0 && pri_r[i] <= best_pri_r) begin
                  best_pri_r <= pri_r[i];
                  best_r     <= i;
                end
              end else if (dl_r[i] != '0) begin
                best_edf_r <= 1'b1;
                best_pri_r <= pri_r[i];
                best_r     <= i;
              end else if (pri_r[i] < best_pri_r) begin
                best_pri_r <= pri_r[i];
                best_r     <= i;
              end
            end
          end
          default: ;
        endcase
      end
      // Commit and form the result
      if (cmd.finish) begin
        res_status         <= ST_OK;
        res_slot_index     <= '0;
        res_chosen_id      <= '0;
        res_context_switch <= 1'b0;
        res_pending_jobs   <= '0;
        res_deadline_out   <= '0;
        res_period_out     <= '0;
        res_priority_out   <= '0;
        res_alive          <= 1'b0;
        res_schedule_requested <= resched_r;
        case (c_r)
          CMD_CREATE: begin
            if (!free_ok_r) res_status <= ST_FULL;
            else if (edf_in_r && pd_r == '0) res_status <= ST_ZERO_DL;
            else begin
              id_r[free_r]     <= ref_r;
              per_r[free_r]    <= per_in_r;
              active_r[free_r] <= 1'b1;
              valid_r[free_r]  <= 1'b1;
              rel_r[free_r]    <= rel_sum;
              pri_r[free_r]    <= edf_in_r ? pd_r + rel_sum : pd_r;
              dl_r[free_r]     <= edf_in_r ? pd_r : '0;
              pend_r[free_r]   <= '0;
              res_slot_index   <= 3'(free_r);
            end
          end
          CMD_DELETE: res_status <= found_r ? ST_OK : ST_NOTFOUND;
          CMD_COMPLETE: begin
            if (!ref_ok) res_status <= ST_NOTFOUND;
            else begin
              if (pend_r[rs] != '0) begin
                pend_r[rs]       <= pend_r[rs] - 16'd1;
                res_pending_jobs <= pend_r[rs] - 16'd1;
              end
              resched_r              <= 1'b1;
              res_schedule_requested <= 1'b1;
              res_slot_index         <= 3'(rs);
            end
          end
          CMD_SCHEDULE: begin
            resched_r              <= 1'b0;
            res_schedule_requested <= 1'b0;
            res_slot_index         <= 3'(best_r);
            res_chosen_id          <= id_r[best_r];
            res_pending_jobs       <= (best_r != '0) ? pend_r[best_r] : '0;
            if (best_r != cur_r) begin
              res_context_switch <= 1'b1;
              cur_r              <= best_r;
            end
          end
          CMD_QUERY: begin
            if (!ref_ok) res_status <= ST_NOTFOUND;
            else begin
              res_slot_index   <= 3'(rs);
              res_chosen_id    <= id_r[rs];
              res_pending_jobs <= pend_r[rs];
              res_deadline_out <= dl_r[rs];
              res_period_out   <= per_r[rs];
              res_priority_out <= pri_r[rs];
              res_alive        <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Idle slot never becomes valid
  a_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0]) else $error("idle slot became valid");
  // Active implies valid
  a_act: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~valid_r) == '0) else $error("active slot not valid");
  // Schedule clears the request
  a_sched: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && c_r == CMD_SCHEDULE |=> !resched_r) else $error("resched kept");
endmodule
